// ----- rtl/core/i2cmts_pkg.sv -----
// Package for the I2C master transfer sequencer.
// Holds phase, action and status codes, the result record and its builder.
// No dependencies.
package i2cmts_pkg;

  localparam int unsigned LengthBitsDefault   = 16;
  localparam int unsigned MaxAddrBytesDefault = 4;

  localparam int unsigned RbufDepth = 4;
  localparam int unsigned RbufPtrW  = $clog2(RbufDepth);
  localparam int unsigned RbufCntW  = $clog2(RbufDepth + 1);

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_BYTE  = 1'b1;

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_ADDR    = 3'd1;
  localparam logic [2:0] PH_SUB     = 3'd2;
  localparam logic [2:0] PH_RESTART = 3'd3;
  localparam logic [2:0] PH_WRITE   = 3'd4;
  localparam logic [2:0] PH_READ    = 3'd5;

  localparam logic [2:0] ACT_START   = 3'd0;
  localparam logic [2:0] ACT_SEND    = 3'd1;
  localparam logic [2:0] ACT_RESTART = 3'd2;
  localparam logic [2:0] ACT_RX_ACK  = 3'd3;
  localparam logic [2:0] ACT_RX_NACK = 3'd4;
  localparam logic [2:0] ACT_STOP    = 3'd5;
  localparam logic [2:0] ACT_DONE    = 3'd6;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BUSY     = 3'd1;
  localparam logic [2:0] ST_ARB      = 3'd2;
  localparam logic [2:0] ST_NAK      = 3'd3;
  localparam logic [2:0] ST_ADDR_NAK = 3'd4;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] bus_byte;
    logic [7:0] read_data;
    logic       read_valid;
    logic [2:0] status;
    logic       engine_reset;
    logic       last;
  } result_t;

  function automatic result_t mk_result(logic [2:0] act, logic [7:0] bb, logic [7:0] rd,
                                        logic rv, logic [2:0] st, logic er, logic lst);
    result_t r;
    r.action       = act;
    r.bus_byte     = bb;
    r.read_data    = rd;
    r.read_valid   = rv;
    r.status       = st;
    r.engine_reset = er;
    r.last         = lst;
    return r;
  endfunction

endpackage

// ----- rtl/core/i2cmts_seq.sv -----
// Transaction state and next-state logic of the I2C master transfer sequencer.
// Turns one accepted request into zero, one or two results.
// Depends on i2cmts_pkg.
module i2cmts_seq import i2cmts_pkg::*; #(
  parameter int unsigned LENGTH_BITS       = LengthBitsDefault,
  parameter int unsigned MAX_ADDRESS_BYTES = MaxAddrBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic        command_i,
  input  logic [6:0]  slave_address_i,
  input  logic        read_not_write_i,
  input  logic [31:0] subaddress_i,
  input  logic [2:0]  subaddress_length_i,
  input  logic [15:0] data_length_i,
  input  logic        bus_busy_i,
  input  logic        nak_seen_i,
  input  logic        arbitration_lost_i,
  input  logic [7:0]  received_byte_i,
  input  logic [7:0]  send_byte_i,
  output logic [1:0]  res_cnt_o,
  output result_t     res0_o,
  output result_t     res1_o
);

  logic [2:0]             phase_q, phase_d;
  logic [6:0]             taddr_q, taddr_d;
  logic                   reading_q, reading_d;
  logic [31:0]            raddr_q, raddr_d;
  logic [2:0]             abl_q, abl_d;
  logic [LENGTH_BITS-1:0] dbl_q, dbl_d;

  logic [LENGTH_BITS-1:0] len_in;
  logic [LENGTH_BITS-1:0] dl_dec;
  logic [2:0]             sublen;
  logic [2:0]             sub_dec;
  logic [7:0]             sub_byte;
  logic                   do_finish, do_begin, do_sub;
  logic [7:0]             fin_rd;
  logic                   fin_rv, fin_er;
  logic [2:0]             fin_st;

  generate
    for (genvar i = 0; i < LENGTH_BITS; i++) begin : g_len
      if (i < 16) begin : g_bit
        assign len_in[i] = data_length_i[i];
      end else begin : g_zero
        assign len_in[i] = 1'b0;
      end
    end
  endgenerate

  assign sublen  = (subaddress_length_i > 3'(MAX_ADDRESS_BYTES)) ?
                   3'(MAX_ADDRESS_BYTES) : subaddress_length_i;
  assign dl_dec  = dbl_q - 1'b1;
  assign sub_dec = abl_q - 3'd1;

  always_comb begin
    case (sub_dec[1:0])
      2'd0:    sub_byte = raddr_q[7:0];
      2'd1:    sub_byte = raddr_q[15:8];
      2'd2:    sub_byte = raddr_q[23:16];
      default: sub_byte = raddr_q[31:24];
    endcase
  end

  always_comb begin
    phase_d   = phase_q;
    taddr_d   = taddr_q;
    reading_d = reading_q;
    raddr_d   = raddr_q;
    abl_d     = abl_q;
    dbl_d     = dbl_q;
    res_cnt_o = 2'd0;
    res0_o    = '0;
    res1_o    = '0;
    do_finish = 1'b0;
    do_begin  = 1'b0;
    do_sub    = 1'b0;
    fin_rd    = 8'd0;
    fin_rv    = 1'b0;
    fin_st    = ST_OK;
    fin_er    = 1'b0;

    if (command_i == CMD_START) begin
      if (phase_q == PH_IDLE) begin
        res_cnt_o = 2'd1;
        if (bus_busy_i) begin
          res0_o = mk_result(ACT_DONE, 8'd0, 8'd0, 1'b0, ST_BUSY, 1'b0, 1'b1);
        end else begin
          taddr_d   = slave_address_i;
          reading_d = read_not_write_i;
          raddr_d   = subaddress_i;
          abl_d     = sublen;
          dbl_d     = len_in;
          phase_d   = PH_ADDR;
          res0_o = mk_result(ACT_START,
                             {slave_address_i, read_not_write_i & (sublen == 3'd0)},
                             8'd0, 1'b0, ST_OK, 1'b0, 1'b1);
        end
      end
    end else if (phase_q == PH_READ) begin
      dbl_d = dl_dec;
      if (dl_dec == '0) begin
        do_finish = 1'b1;
        fin_rd    = received_byte_i;
        fin_rv    = 1'b1;
      end else begin
        res_cnt_o = 2'd1;
        res0_o = mk_result((dl_dec == LENGTH_BITS'(1)) ? ACT_RX_NACK : ACT_RX_ACK,
                           8'd0, received_byte_i, 1'b1, ST_OK, 1'b0, 1'b1);
      end
    end else if (phase_q != PH_IDLE) begin
      if (arbitration_lost_i) begin
        do_finish = 1'b1;
        fin_st    = ST_ARB;
        fin_er    = 1'b1;
      end else if (nak_seen_i) begin
        do_finish = 1'b1;
        fin_st    = (phase_q == PH_RESTART) ? ST_ADDR_NAK : ST_NAK;
      end else begin
        case (phase_q)
          PH_ADDR: begin
            if (abl_q != 3'd0) do_sub = 1'b1;
            else do_begin = 1'b1;
          end
          PH_SUB: begin
            if (abl_q != 3'd0) begin
              do_sub = 1'b1;
            end else if (reading_q) begin
              phase_d   = PH_RESTART;
              res_cnt_o = 2'd1;
              res0_o = mk_result(ACT_RESTART, {taddr_q, 1'b1}, 8'd0, 1'b0, ST_OK,
                                 1'b0, 1'b1);
            end else begin
              do_begin = 1'b1;
            end
          end
          PH_RESTART: do_begin = 1'b1;
          PH_WRITE: begin
            dbl_d = dl_dec;
            if (dl_dec == '0) begin
              do_finish = 1'b1;
            end else begin
              res_cnt_o = 2'd1;
              res0_o = mk_result(ACT_SEND, send_byte_i, 8'd0, 1'b0, ST_OK, 1'b0, 1'b1);
            end
          end
          default: phase_d = PH_IDLE;
        endcase
      end
    end

    if (do_sub) begin
      abl_d     = sub_dec;
      phase_d   = PH_SUB;
      res_cnt_o = 2'd1;
      res0_o    = mk_result(ACT_SEND, sub_byte, 8'd0, 1'b0, ST_OK, 1'b0, 1'b1);
    end

    if (do_begin) begin
      if (dbl_q == '0) begin
        do_finish = 1'b1;
      end else if (reading_q) begin
        phase_d   = PH_READ;
        res_cnt_o = 2'd1;
        res0_o = mk_result((dbl_q == LENGTH_BITS'(1)) ? ACT_RX_NACK : ACT_RX_ACK,
                           8'd0, 8'd0, 1'b0, ST_OK, 1'b0, 1'b1);
      end else begin
        phase_d   = PH_WRITE;
        res_cnt_o = 2'd1;
        res0_o = mk_result(ACT_SEND, send_byte_i, 8'd0, 1'b0, ST_OK, 1'b0, 1'b1);
      end
    end

    if (do_finish) begin
      phase_d   = PH_IDLE;
      res_cnt_o = 2'd2;
      res0_o    = mk_result(ACT_STOP, 8'd0, fin_rd, fin_rv, ST_OK, fin_er, 1'b0);
      res1_o    = mk_result(ACT_DONE, 8'd0, 8'd0, 1'b0, fin_st, 1'b0, 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      taddr_q   <= '0;
      reading_q <= 1'b0;
      raddr_q   <= '0;
      abl_q     <= '0;
      dbl_q     <= '0;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      taddr_q   <= taddr_d;
      reading_q <= reading_d;
      raddr_q   <= raddr_d;
      abl_q     <= abl_d;
      dbl_q     <= dbl_d;
    end
  end

endmodule

// ----- rtl/core/i2cmts_rbuf.sv -----
// Result buffer of the I2C master transfer sequencer.
// Small queue that takes up to two results per cycle and hands out one when ready.
// Depends on i2cmts_pkg.
module i2cmts_rbuf import i2cmts_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] push_cnt_i,
  input  result_t    push0_i,
  input  result_t    push1_i,
  output logic       space_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output result_t    out_o
);

  result_t               mem_q [RbufDepth];
  logic [RbufPtrW-1:0]   wr_q, wr_d, rd_q, rd_d, wr_nxt;
  logic [RbufCntW-1:0]   cnt_q, cnt_d;
  logic                  pop;

  assign pop         = out_valid_o & out_ready_i;
  assign out_valid_o = cnt_q != '0;
  assign out_o       = mem_q[rd_q];
  assign space_o     = cnt_q <= RbufCntW'(RbufDepth - 2);
  assign wr_nxt      = wr_q + 1'b1;
  assign wr_d        = wr_q + RbufPtrW'(push_cnt_i);
  assign rd_d        = rd_q + RbufPtrW'(pop);
  assign cnt_d       = cnt_q + RbufCntW'(push_cnt_i) - RbufCntW'(pop);

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) mem_q[wr_q] <= push0_i;
    if (push_cnt_i == 2'd2) mem_q[wr_nxt] <= push1_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- rtl/core/i2c_master_transfer_sequencer_unit.sv -----
// Top level of the I2C master transfer sequencer.
// Joins the transaction logic (i2cmts_seq) and the result queue (i2cmts_rbuf).
// Depends on i2cmts_pkg.
//
//   channel  direction  handshake                  payload
//   request  in         in_valid_i / in_ready_o    command_i .. send_byte_i
//   result   out        out_valid_o / out_ready_i  action_o .. last_o
//
// One request per cycle is taken while in_ready_o is high; its results enter the queue
// at that edge, offered from the next cycle, one per cycle while out_ready_i is high.
// A request causes zero, one or two results; stop and finished go out as two results.
// in_ready_o drops only when the four-entry result queue has room for fewer than two.
// Reset clears the phase, the transaction registers and the queue.
module i2c_master_transfer_sequencer_unit import i2cmts_pkg::*; #(
  parameter int unsigned LENGTH_BITS       = LengthBitsDefault,
  parameter int unsigned MAX_ADDRESS_BYTES = MaxAddrBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [6:0]  slave_address_i,
  input  logic        read_not_write_i,
  input  logic [31:0] subaddress_i,
  input  logic [2:0]  subaddress_length_i,
  input  logic [15:0] data_length_i,
  input  logic        bus_busy_i,
  input  logic        nak_seen_i,
  input  logic        arbitration_lost_i,
  input  logic [7:0]  received_byte_i,
  input  logic [7:0]  send_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  action_o,
  output logic [7:0]  bus_byte_o,
  output logic [7:0]  read_data_o,
  output logic        read_valid_o,
  output logic [2:0]  status_o,
  output logic        engine_reset_o,
  output logic        last_o
);

  logic       accept;
  logic [1:0] res_cnt;
  logic [1:0] push_cnt;
  result_t    res0, res1, res_out;

  assign accept   = in_valid_i & in_ready_o;
  assign push_cnt = accept ? res_cnt : 2'd0;

  i2cmts_seq #(
    .LENGTH_BITS      (LENGTH_BITS),
    .MAX_ADDRESS_BYTES(MAX_ADDRESS_BYTES)
  ) u_seq (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .accept_i           (accept),
    .command_i          (command_i),
    .slave_address_i    (slave_address_i),
    .read_not_write_i   (read_not_write_i),
    .subaddress_i       (subaddress_i),
    .subaddress_length_i(subaddress_length_i),
    .data_length_i      (data_length_i),
    .bus_busy_i         (bus_busy_i),
    .nak_seen_i         (nak_seen_i),
    .arbitration_lost_i (arbitration_lost_i),
    .received_byte_i    (received_byte_i),
    .send_byte_i        (send_byte_i),
    .res_cnt_o          (res_cnt),
    .res0_o             (res0),
    .res1_o             (res1)
  );

  i2cmts_rbuf u_rbuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (push_cnt),
    .push0_i    (res0),
    .push1_i    (res1),
    .space_o    (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (res_out)
  );

  assign action_o       = res_out.action;
  assign bus_byte_o     = res_out.bus_byte;
  assign read_data_o    = res_out.read_data;
  assign read_valid_o   = res_out.read_valid;
  assign status_o       = res_out.status;
  assign engine_reset_o = res_out.engine_reset;
  assign last_o         = res_out.last;

endmodule

// ----- sim/tb_top.sv -----
// Testbench for i2c_master_transfer_sequencer_unit: a directed table, then random transfers.
// A phase model predicts untyped results, typed rows carry theirs; all checked in order.
// Depends on i2cmts_pkg and i2c_master_transfer_sequencer_unit.
module tb_top import i2cmts_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        cmd;
    logic [6:0]  addr;
    logic        rnw;
    logic [31:0] sub;
    logic [2:0]  sub_len;
    logic [15:0] data_len;
    logic        busy;
    logic        nak;
    logic        arb;
    logic [7:0]  rx_byte;
    logic [7:0]  tx_byte;
  } request_t;

  typedef struct {
    request_t req;
    bit       typed;
    int       n_res;
    result_t  res0;
    result_t  res1;
  } directed_row_t;

  logic     clk_i;
  logic     rst_ni = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready_o;
  request_t req_drv = '0;
  logic     out_valid_o;
  logic     out_ready = 1'b0;
  logic [2:0] action_o;
  logic [7:0] bus_byte_o;
  logic [7:0] read_data_o;
  logic       read_valid_o;
  logic [2:0] status_o;
  logic       engine_reset_o;
  logic       last_o;

  // transfer state as seen by the predictor
  logic [2:0]  xfer_phase = PH_IDLE;
  logic [6:0]  xfer_target = '0;
  logic        xfer_reading = 1'b0;
  logic [31:0] xfer_reg_addr = '0;
  logic [2:0]  xfer_addr_left = '0;
  logic [15:0] xfer_data_left = '0;

  result_t       pending_results[$];
  directed_row_t directed_rows[$];
  int            mismatches = 0;
  int unsigned   send_idle_pct = 0;
  int unsigned   stall_pct = 0;
  bit            hold_req = 1'b0;
  int            hold_left = 0;

  i2c_master_transfer_sequencer_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready_o),
    .command_i          (req_drv.cmd),
    .slave_address_i    (req_drv.addr),
    .read_not_write_i   (req_drv.rnw),
    .subaddress_i       (req_drv.sub),
    .subaddress_length_i(req_drv.sub_len),
    .data_length_i      (req_drv.data_len),
    .bus_busy_i         (req_drv.busy),
    .nak_seen_i         (req_drv.nak),
    .arbitration_lost_i (req_drv.arb),
    .received_byte_i    (req_drv.rx_byte),
    .send_byte_i        (req_drv.tx_byte),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready),
    .action_o           (action_o),
    .bus_byte_o         (bus_byte_o),
    .read_data_o        (read_data_o),
    .read_valid_o       (read_valid_o),
    .status_o           (status_o),
    .engine_reset_o     (engine_reset_o),
    .last_o             (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("FAIL i2c_master_transfer_sequencer_unit");
    $finish;
  end

  task automatic transfer_step(input request_t rq, output int n, output result_t r0,
                               output result_t r1);
    logic [2:0] sl;
    bit         do_sub;
    bit         do_data;
    bit         do_finish;
    logic [7:0] fin_rd;
    logic       fin_rv;
    logic       fin_er;
    logic [2:0] fin_st;
    n = 0;
    r0 = '0;
    r1 = '0;
    do_sub = 1'b0;
    do_data = 1'b0;
    do_finish = 1'b0;
    fin_rd = '0;
    fin_rv = 1'b0;
    fin_er = 1'b0;
    fin_st = ST_OK;
    if (rq.cmd == CMD_START) begin
      if (xfer_phase == PH_IDLE && rq.busy) begin
        r0 = mk_result(ACT_DONE, 8'h00, 8'h00, 1'b0, ST_BUSY, 1'b0, 1'b1);
        n = 1;
      end else if (xfer_phase == PH_IDLE) begin
        sl = (rq.sub_len > 3'd4) ? 3'd4 : rq.sub_len;
        xfer_target = rq.addr;
        xfer_reading = rq.rnw;
        xfer_reg_addr = rq.sub;
        xfer_addr_left = sl;
        xfer_data_left = rq.data_len;
        xfer_phase = PH_ADDR;
        r0 = mk_result(ACT_START, {rq.addr, rq.rnw & (sl == 3'd0)}, 8'h00, 1'b0, ST_OK,
                       1'b0, 1'b1);
        n = 1;
      end
    end else if (xfer_phase == PH_READ) begin
      xfer_data_left = xfer_data_left - 16'd1;
      if (xfer_data_left == 16'd0) begin
        do_finish = 1'b1;
        fin_rd = rq.rx_byte;
        fin_rv = 1'b1;
      end else begin
        r0 = mk_result((xfer_data_left == 16'd1) ? ACT_RX_NACK : ACT_RX_ACK, 8'h00,
                       rq.rx_byte, 1'b1, ST_OK, 1'b0, 1'b1);
        n = 1;
      end
    end else if (xfer_phase != PH_IDLE) begin
      if (rq.arb) begin
        do_finish = 1'b1;
        fin_st = ST_ARB;
        fin_er = 1'b1;
      end else if (rq.nak) begin
        do_finish = 1'b1;
        fin_st = (xfer_phase == PH_RESTART) ? ST_ADDR_NAK : ST_NAK;
      end else begin
        case (xfer_phase)
          PH_ADDR: begin
            if (xfer_addr_left != 3'd0) do_sub = 1'b1;
            else do_data = 1'b1;
          end
          PH_SUB: begin
            if (xfer_addr_left != 3'd0) begin
              do_sub = 1'b1;
            end else if (xfer_reading) begin
              xfer_phase = PH_RESTART;
              r0 = mk_result(ACT_RESTART, {xfer_target, 1'b1}, 8'h00, 1'b0, ST_OK, 1'b0,
                             1'b1);
              n = 1;
            end else begin
              do_data = 1'b1;
            end
          end
          PH_RESTART: do_data = 1'b1;
          PH_WRITE: begin
            xfer_data_left = xfer_data_left - 16'd1;
            if (xfer_data_left == 16'd0) begin
              do_finish = 1'b1;
            end else begin
              r0 = mk_result(ACT_SEND, rq.tx_byte, 8'h00, 1'b0, ST_OK, 1'b0, 1'b1);
              n = 1;
            end
          end
          default: xfer_phase = PH_IDLE;
        endcase
      end
    end
    if (do_sub) begin
      xfer_addr_left = xfer_addr_left - 3'd1;
      xfer_phase = PH_SUB;
      r0 = mk_result(ACT_SEND, 8'(xfer_reg_addr >> (8 * xfer_addr_left[1:0])), 8'h00,
                     1'b0, ST_OK, 1'b0, 1'b1);
      n = 1;
    end
    if (do_data) begin
      if (xfer_data_left == 16'd0) begin
        do_finish = 1'b1;
      end else if (xfer_reading) begin
        xfer_phase = PH_READ;
        r0 = mk_result((xfer_data_left == 16'd1) ? ACT_RX_NACK : ACT_RX_ACK, 8'h00, 8'h00,
                       1'b0, ST_OK, 1'b0, 1'b1);
        n = 1;
      end else begin
        xfer_phase = PH_WRITE;
        r0 = mk_result(ACT_SEND, rq.tx_byte, 8'h00, 1'b0, ST_OK, 1'b0, 1'b1);
        n = 1;
      end
    end
    if (do_finish) begin
      r0 = mk_result(ACT_STOP, 8'h00, fin_rd, fin_rv, ST_OK, fin_er, 1'b0);
      r1 = mk_result(ACT_DONE, 8'h00, 8'h00, 1'b0, fin_st, 1'b0, 1'b1);
      n = 2;
      xfer_phase = PH_IDLE;
    end
  endtask

  task automatic offer(input request_t rq, input bit typed, input int typed_n,
                       input result_t typed0, input result_t typed1);
    int      n;
    result_t r0;
    result_t r1;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    req_drv <= rq;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    transfer_step(rq, n, r0, r1);
    if (typed) begin
      n = typed_n;
      r0 = typed0;
      r1 = typed1;
    end
    if (n > 0) pending_results.push_back(r0);
    if (n > 1) pending_results.push_back(r1);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic add_row(input request_t rq, input bit typed, input int n,
                         input result_t r0, input result_t r1);
    directed_row_t row;
    row.req = rq;
    row.typed = typed;
    row.n_res = n;
    row.res0 = r0;
    row.res1 = r1;
    directed_rows.push_back(row);
  endtask

  function automatic request_t start_req(logic [6:0] addr, logic rnw, logic [31:0] sub,
                                         logic [2:0] sub_len, logic [15:0] len, logic busy);
    request_t rq;
    rq = '0;
    rq.cmd = CMD_START;
    rq.addr = addr;
    rq.rnw = rnw;
    rq.sub = sub;
    rq.sub_len = sub_len;
    rq.data_len = len;
    rq.busy = busy;
    return rq;
  endfunction

  function automatic request_t byte_req(logic nak, logic arb, logic [7:0] rx, logic [7:0] tx);
    request_t rq;
    rq = '0;
    rq.cmd = CMD_BYTE;
    rq.nak = nak;
    rq.arb = arb;
    rq.rx_byte = rx;
    rq.tx_byte = tx;
    return rq;
  endfunction

  task automatic check_field(input string what, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  // receiver: random stalls, or a long hold-off when asked
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 64;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none pending, actual action %0d", $time, action_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("action", want.action, action_o);
        check_field("bus_byte", want.bus_byte, bus_byte_o);
        check_field("read_data", want.read_data, read_data_o);
        check_field("read_valid", want.read_valid, read_valid_o);
        check_field("status", want.status, status_o);
        check_field("engine_reset", want.engine_reset, engine_reset_o);
        check_field("last", want.last, last_o);
      end
    end
  end

  initial begin : stimulus
    int unsigned send_pcts[4];
    int unsigned stall_pcts[4];
    request_t    rq;
    int          counted;
    bit          ignored;
    send_pcts = '{0, 80, 0, 24};
    stall_pcts = '{0, 0, 80, 24};

    add_row(byte_req(1'b0, 1'b0, 8'h5A, 8'hA5), 1'b1, 0, '0, '0);
    add_row(start_req(7'h12, 1'b0, 32'h0, 3'd0, 16'd1, 1'b1), 1'b1, 1,
            mk_result(ACT_DONE, 8'h00, 8'h00, 1'b0, ST_BUSY, 1'b0, 1'b1), '0);
    add_row(start_req(7'h7F, 1'b0, 32'hFFFF_FFFF, 3'd0, 16'd1, 1'b0), 1'b1, 1,
            mk_result(ACT_START, 8'hFE, 8'h00, 1'b0, ST_OK, 1'b0, 1'b1), '0);
    add_row(start_req(7'h01, 1'b1, 32'h0, 3'd2, 16'd3, 1'b0), 1'b1, 0, '0, '0);
    add_row(byte_req(1'b0, 1'b0, 8'h00, 8'hFF), 1'b1, 1,
            mk_result(ACT_SEND, 8'hFF, 8'h00, 1'b0, ST_OK, 1'b0, 1'b1), '0);
    add_row(byte_req(1'b0, 1'b0, 8'h00, 8'h00), 1'b1, 2,
            mk_result(ACT_STOP, 8'h00, 8'h00, 1'b0, ST_OK, 1'b0, 1'b0),
            mk_result(ACT_DONE, 8'h00, 8'h00, 1'b0, ST_OK, 1'b0, 1'b1));
    add_row(start_req(7'h00, 1'b1, 32'hA1B2_C3D4, 3'd7, 16'd2, 1'b0), 1'b0, 0, '0, '0);
    for (int i = 0; i < 5; i++) add_row(byte_req(1'b0, 1'b0, 8'h3C, 8'h96), 1'b0, 0, '0, '0);
    add_row(byte_req(1'b0, 1'b0, 8'h81, 8'h18), 1'b0, 0, '0, '0);
    add_row(byte_req(1'b1, 1'b1, 8'hFF, 8'h00), 1'b0, 0, '0, '0);
    add_row(byte_req(1'b0, 1'b0, 8'h00, 8'hFF), 1'b0, 0, '0, '0);
    add_row(start_req(7'h55, 1'b1, 32'h0000_00C3, 3'd1, 16'd3, 1'b0), 1'b0, 0, '0, '0);
    add_row(byte_req(1'b0, 1'b0, 8'h11, 8'h22), 1'b0, 0, '0, '0);
    add_row(byte_req(1'b0, 1'b0, 8'h33, 8'h44), 1'b0, 0, '0, '0);
    add_row(byte_req(1'b1, 1'b0, 8'h00, 8'h00), 1'b1, 2,
            mk_result(ACT_STOP, 8'h00, 8'h00, 1'b0, ST_OK, 1'b0, 1'b0),
            mk_result(ACT_DONE, 8'h00, 8'h00, 1'b0, ST_ADDR_NAK, 1'b0, 1'b1));
    add_row(start_req(7'h33, 1'b0, 32'h0, 3'd0, 16'd0, 1'b0), 1'b0, 0, '0, '0);
    add_row(byte_req(1'b0, 1'b0, 8'h00, 8'h00), 1'b1, 2,
            mk_result(ACT_STOP, 8'h00, 8'h00, 1'b0, ST_OK, 1'b0, 1'b0),
            mk_result(ACT_DONE, 8'h00, 8'h00, 1'b0, ST_OK, 1'b0, 1'b1));
    add_row(start_req(7'h40, 1'b0, 32'h1234_5678, 3'd2, 16'd5, 1'b0), 1'b0, 0, '0, '0);
    add_row(byte_req(1'b1, 1'b1, 8'h00, 8'h00), 1'b1, 2,
            mk_result(ACT_STOP, 8'h00, 8'h00, 1'b0, ST_OK, 1'b1, 1'b0),
            mk_result(ACT_DONE, 8'h00, 8'h00, 1'b0, ST_ARB, 1'b0, 1'b1));
    add_row(start_req(7'h2A, 1'b1, 32'h0, 3'd0, 16'hFFFF, 1'b0), 1'b1, 1,
            mk_result(ACT_START, 8'h55, 8'h00, 1'b0, ST_OK, 1'b0, 1'b1), '0);
    add_row(byte_req(1'b1, 1'b0, 8'h00, 8'h00), 1'b1, 2,
            mk_result(ACT_STOP, 8'h00, 8'h00, 1'b0, ST_OK, 1'b0, 1'b0),
            mk_result(ACT_DONE, 8'h00, 8'h00, 1'b0, ST_NAK, 1'b0, 1'b1));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      offer(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].n_res,
            directed_rows[i].res0, directed_rows[i].res1);
    drain_results();

    for (int mode = 0; mode < 4; mode++) begin
      send_idle_pct = send_pcts[mode];
      stall_pct = stall_pcts[mode];
      if (mode == 0) hold_req = 1'b1;
      counted = 0;
      while (counted < 75) begin
        rq.addr = 7'($urandom_range(127));
        rq.rnw = 1'($urandom_range(1));
        rq.sub = $urandom;
        rq.sub_len = 3'($urandom_range(7));
        rq.data_len = 16'($urandom_range(65535));
        rq.busy = 1'b0;
        rq.nak = 1'b0;
        rq.arb = 1'b0;
        rq.rx_byte = 8'($urandom_range(255));
        rq.tx_byte = 8'($urandom_range(255));
        if (xfer_phase == PH_IDLE) begin
          rq.cmd = ($urandom_range(99) < 8) ? CMD_BYTE : CMD_START;
          rq.busy = ($urandom_range(9) == 0);
          if ($urandom_range(9) != 0) rq.data_len = 16'($urandom_range(5));
        end else begin
          rq.cmd = ($urandom_range(99) < 4) ? CMD_START : CMD_BYTE;
          rq.nak = ($urandom_range(99) < 5);
          rq.arb = ($urandom_range(99) < 4);
          // abort long transfers as they enter the data stage or while writing
          if (xfer_data_left > 16'd16 && xfer_phase != PH_READ &&
              (xfer_phase == PH_RESTART || xfer_phase == PH_WRITE ||
               (xfer_addr_left == 3'd0 && !(xfer_phase == PH_SUB && xfer_reading)))) begin
            if ($urandom_range(1) == 0) rq.nak = 1'b1;
            else rq.arb = 1'b1;
          end
        end
        ignored = (rq.cmd == CMD_START) != (xfer_phase == PH_IDLE);
        if (!ignored) counted++;
        offer(rq, 1'b0, 0, '0, '0);
      end
      drain_results();
    end

    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASS i2c_master_transfer_sequencer_unit");
    end else begin
      $display("FAIL i2c_master_transfer_sequencer_unit");
    end
    $finish;
  end

endmodule
